// File: src/bcc_pkg.sv
// ============================================================================
// Barycentric coordinate unit package
// Shared widths, stage counts, payload structs and helper functions.
// ============================================================================
package bcc_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int NUM_COORDS   = 12;
    localparam int NUM_LANES    = 3;
    localparam int NUM_CROSS    = NUM_LANES + 1;
    localparam int NUM_COMP     = 3;

    // Exact widths of the intermediate values.
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int MPROD_W      = 2 * DIFF_W;
    localparam int CROSS_W      = MPROD_W + 1;
    localparam int SPLIT_LO     = (CROSS_W + 1) / 2;
    localparam int SPLIT_HI     = CROSS_W - SPLIT_LO;
    localparam int MID_W        = SPLIT_HI + SPLIT_LO + 1;
    localparam int PROD_W       = 2 * CROSS_W;
    localparam int AREA_W       = PROD_W + 2;

    // Division and output format.
    localparam int FRAC_W       = 16;
    localparam int OUT_W        = 32;
    localparam int QUO_W        = OUT_W + 1;
    localparam int OVF_SHIFT    = QUO_W - FRAC_W;
    localparam int REM_W        = AREA_W + QUO_W;

    // Pipeline depth of each section.
    localparam int CROSS_STAGES = 3;
    localparam int DOT_STAGES   = 5;
    localparam int DIV_STAGES   = QUO_W;

    // Stream widths.
    localparam int IN_TDATA_W   = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = NUM_LANES * OUT_W;

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [MPROD_W-1:0]     mprod_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } cvec_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
        diff_t z;
    } dvec_t;

    typedef struct packed {
        cross_t x;
        cross_t y;
        cross_t z;
    } xvec_t;

    // Triangle normal and the three sub-triangle edge cross products.
    typedef struct packed {
        xvec_t                 nrm;
        xvec_t [NUM_LANES-1:0] ecr;
    } cross_set_t;

    typedef struct packed {
        logic [AREA_W-1:0]                  total;
        logic [NUM_LANES-1:0][AREA_W-1:0]   mag;
        logic [NUM_LANES-1:0]               neg;
        logic [NUM_LANES-1:0]               ovf;
        logic                               degen;
    } div_in_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][QUO_W-1:0]    quo;
        logic [NUM_LANES-1:0]               neg;
        logic [NUM_LANES-1:0]               ovf;
        logic                               degen;
    } div_out_t;

    function automatic dvec_t vdiff(cvec_t p, cvec_t q);
        dvec_t r;
        r.x = $signed({p.x[COORD_WIDTH-1], p.x}) - $signed({q.x[COORD_WIDTH-1], q.x});
        r.y = $signed({p.y[COORD_WIDTH-1], p.y}) - $signed({q.y[COORD_WIDTH-1], q.y});
        r.z = $signed({p.z[COORD_WIDTH-1], p.z}) - $signed({q.z[COORD_WIDTH-1], q.z});
        return r;
    endfunction

    function automatic cross_t xsub(mprod_t a, mprod_t b);
        cross_t ea;
        cross_t eb;
        ea = CROSS_W'(a);
        eb = CROSS_W'(b);
        return ea - eb;
    endfunction

    // Turns a quotient magnitude into a saturated signed Q16.16 weight.
    function automatic logic [OUT_W-1:0] sat_weight(logic [QUO_W-1:0] q, logic neg,
                                                    logic ovf, logic degen);
        logic [OUT_W-1:0] lo;
        logic [OUT_W-1:0] res;
        lo = q[OUT_W-1:0];
        priority if (degen)                              res = '0;
        else if (ovf)                                    res = neg ? SAT_NEG : SAT_POS;
        else if (neg && (q > QUO_W'(SAT_NEG)))           res = SAT_NEG;
        else if (neg)                                    res = '0 - lo;
        else if (q > QUO_W'(SAT_POS))                    res = SAT_POS;
        else                                             res = lo;
        return res;
    endfunction

endpackage

// File: src/bcc_cross.sv
// ============================================================================
// Cross product section
// Edge differences, partial products and cross products in three stages.
// ============================================================================
module bcc_cross (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bcc_pkg::cvec_t       pa,
    input  bcc_pkg::cvec_t       pb,
    input  bcc_pkg::cvec_t       pc,
    input  bcc_pkg::cvec_t       pp,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bcc_pkg::cross_set_t  out_data
);
    import bcc_pkg::*;

    logic [CROSS_STAGES-1:0] vld_reg;
    logic [CROSS_STAGES-1:0] vld_next;
    logic [CROSS_STAGES:0]   rdy;

    dvec_t  u_reg   [NUM_CROSS];
    dvec_t  v_reg   [NUM_CROSS];
    mprod_t mul_reg [NUM_CROSS][6];
    xvec_t  cr_reg  [NUM_CROSS];

    // A stage takes new data when it is empty or its successor moves on.
    always_comb
    begin
        rdy[CROSS_STAGES] = out_ready;
        for (int i = CROSS_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next = {vld_reg[CROSS_STAGES-2:0], in_valid};
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[CROSS_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < CROSS_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // Operand pairs: normal, then the alpha, beta and gamma edges.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            u_reg[0] <= vdiff(pb, pa);
            v_reg[0] <= vdiff(pc, pa);
            u_reg[1] <= vdiff(pc, pb);
            v_reg[1] <= vdiff(pp, pb);
            u_reg[2] <= vdiff(pa, pc);
            v_reg[2] <= vdiff(pp, pc);
            u_reg[3] <= vdiff(pb, pa);
            v_reg[3] <= vdiff(pp, pa);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int k = 0; k < NUM_CROSS; k++)
            begin
                mul_reg[k][0] <= $signed(u_reg[k].y) * $signed(v_reg[k].z);
                mul_reg[k][1] <= $signed(u_reg[k].z) * $signed(v_reg[k].y);
                mul_reg[k][2] <= $signed(u_reg[k].z) * $signed(v_reg[k].x);
                mul_reg[k][3] <= $signed(u_reg[k].x) * $signed(v_reg[k].z);
                mul_reg[k][4] <= $signed(u_reg[k].x) * $signed(v_reg[k].y);
                mul_reg[k][5] <= $signed(u_reg[k].y) * $signed(v_reg[k].x);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int k = 0; k < NUM_CROSS; k++)
            begin
                cr_reg[k].x <= xsub(mul_reg[k][0], mul_reg[k][1]);
                cr_reg[k].y <= xsub(mul_reg[k][2], mul_reg[k][3]);
                cr_reg[k].z <= xsub(mul_reg[k][4], mul_reg[k][5]);
            end
        end
    end

    always_comb
    begin
        out_data.nrm = cr_reg[0];
        for (int l = 0; l < NUM_LANES; l++)
        begin
            out_data.ecr[l] = cr_reg[l+1];
        end
    end

endmodule

// File: src/bcc_dot.sv
// ============================================================================
// Dot product section
// Split multiplies, products, sums, magnitudes and overflow test in five stages.
// ============================================================================
module bcc_dot (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bcc_pkg::cross_set_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bcc_pkg::div_in_t     out_data
);
    import bcc_pkg::*;

    logic [DOT_STAGES-1:0] vld_reg;
    logic [DOT_STAGES-1:0] vld_next;
    logic [DOT_STAGES:0]   rdy;

    cross_t oa [NUM_CROSS][NUM_COMP];
    cross_t ob [NUM_COMP];

    logic        [2*SPLIT_LO-1:0] ll_reg [NUM_CROSS][NUM_COMP];
    logic signed [MID_W-1:0]      lh_reg [NUM_CROSS][NUM_COMP];
    logic signed [MID_W-1:0]      hl_reg [NUM_CROSS][NUM_COMP];
    logic signed [2*SPLIT_HI-1:0] hh_reg [NUM_CROSS][NUM_COMP];
    logic signed [PROD_W-1:0]     prod_reg [NUM_CROSS][NUM_COMP];
    logic signed [PROD_W-1:0]     prod_next [NUM_CROSS][NUM_COMP];
    logic signed [AREA_W-1:0]     dot_reg [NUM_CROSS];
    logic [AREA_W-1:0]            tot_reg;
    logic [NUM_LANES-1:0][AREA_W-1:0] mag_reg;
    logic [NUM_LANES-1:0]         neg_reg;
    logic                         degen_reg;
    div_in_t                      out_reg;

    always_comb
    begin
        rdy[DOT_STAGES] = out_ready;
        for (int i = DOT_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next = {vld_reg[DOT_STAGES-2:0], in_valid};
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[DOT_STAGES-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < DOT_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // Dot zero is the normal with itself; the others are edge crosses with it.
    always_comb
    begin
        ob[0] = in_data.nrm.x;
        ob[1] = in_data.nrm.y;
        ob[2] = in_data.nrm.z;
        oa[0][0] = in_data.nrm.x;
        oa[0][1] = in_data.nrm.y;
        oa[0][2] = in_data.nrm.z;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            oa[l+1][0] = in_data.ecr[l].x;
            oa[l+1][1] = in_data.ecr[l].y;
            oa[l+1][2] = in_data.ecr[l].z;
        end
    end

    // Each wide product is cut into four partial products of about half width.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int d = 0; d < NUM_CROSS; d++)
            begin
                for (int c = 0; c < NUM_COMP; c++)
                begin
                    ll_reg[d][c] <= oa[d][c][SPLIT_LO-1:0] * ob[c][SPLIT_LO-1:0];
                    lh_reg[d][c] <= $signed(oa[d][c][CROSS_W-1:SPLIT_LO])
                                  * $signed({1'b0, ob[c][SPLIT_LO-1:0]});
                    hl_reg[d][c] <= $signed({1'b0, oa[d][c][SPLIT_LO-1:0]})
                                  * $signed(ob[c][CROSS_W-1:SPLIT_LO]);
                    hh_reg[d][c] <= $signed(oa[d][c][CROSS_W-1:SPLIT_LO])
                                  * $signed(ob[c][CROSS_W-1:SPLIT_LO]);
                end
            end
        end
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] e_ll;
        logic signed [PROD_W-1:0] e_mid;
        logic signed [PROD_W-1:0] e_hh;
        for (int d = 0; d < NUM_CROSS; d++)
        begin
            for (int c = 0; c < NUM_COMP; c++)
            begin
                e_ll  = $signed({{(PROD_W-2*SPLIT_LO){1'b0}}, ll_reg[d][c]});
                e_mid = PROD_W'(lh_reg[d][c]) + PROD_W'(hl_reg[d][c]);
                e_hh  = PROD_W'(hh_reg[d][c]);
                prod_next[d][c] = e_ll + (e_mid <<< SPLIT_LO) + (e_hh <<< (2*SPLIT_LO));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int d = 0; d < NUM_CROSS; d++)
            begin
                dot_reg[d] <= AREA_W'(prod_reg[d][0]) + AREA_W'(prod_reg[d][1])
                            + AREA_W'(prod_reg[d][2]);
            end
        end
    end

    // The total is a squared length and never negative.
    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            tot_reg   <= dot_reg[0];
            degen_reg <= (dot_reg[0] == '0);
            for (int l = 0; l < NUM_LANES; l++)
            begin
                neg_reg[l] <= dot_reg[l+1][AREA_W-1];
                mag_reg[l] <= dot_reg[l+1][AREA_W-1] ? AREA_W'(-dot_reg[l+1])
                                                     : dot_reg[l+1];
            end
        end
    end

    // A quotient that needs more than the divider's bits saturates.
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            out_reg.total <= tot_reg;
            out_reg.mag   <= mag_reg;
            out_reg.neg   <= neg_reg;
            out_reg.degen <= degen_reg;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                out_reg.ovf[l] <= ({{OVF_SHIFT{1'b0}}, mag_reg[l]}
                                   >= {tot_reg, {OVF_SHIFT{1'b0}}});
            end
        end
    end

endmodule

// File: src/bcc_div.sv
// ============================================================================
// Divider section
// Three restoring dividers, one quotient bit per pipeline stage.
// ============================================================================
module bcc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bcc_pkg::div_in_t     in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bcc_pkg::div_out_t    out_data
);
    import bcc_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] vld_next;
    logic [DIV_STAGES:0]   rdy;

    logic [REM_W-1:0]     rem_reg   [DIV_STAGES][NUM_LANES];
    logic [QUO_W-1:0]     quo_reg   [DIV_STAGES][NUM_LANES];
    logic [AREA_W-1:0]    tot_reg   [DIV_STAGES];
    logic [NUM_LANES-1:0] neg_reg   [DIV_STAGES];
    logic [NUM_LANES-1:0] ovf_reg   [DIV_STAGES];
    logic                 degen_reg [DIV_STAGES];

    logic [REM_W-1:0]     rem_src   [DIV_STAGES][NUM_LANES];
    logic [QUO_W-1:0]     quo_src   [DIV_STAGES][NUM_LANES];
    logic [AREA_W-1:0]    tot_src   [DIV_STAGES];
    logic [NUM_LANES-1:0] neg_src   [DIV_STAGES];
    logic [NUM_LANES-1:0] ovf_src   [DIV_STAGES];
    logic                 degen_src [DIV_STAGES];

    always_comb
    begin
        rdy[DIV_STAGES] = out_ready;
        for (int i = DIV_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next = {vld_reg[DIV_STAGES-2:0], in_valid};
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // The first stage starts from the scaled magnitude; later ones from the previous.
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rem_src[0][l] = REM_W'({in_data.mag[l], {FRAC_W{1'b0}}});
            quo_src[0][l] = '0;
        end
        tot_src[0]   = in_data.total;
        neg_src[0]   = in_data.neg;
        ovf_src[0]   = in_data.ovf;
        degen_src[0] = in_data.degen;
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            rem_src[j]   = rem_reg[j-1];
            quo_src[j]   = quo_reg[j-1];
            tot_src[j]   = tot_reg[j-1];
            neg_src[j]   = neg_reg[j-1];
            ovf_src[j]   = ovf_reg[j-1];
            degen_src[j] = degen_reg[j-1];
        end
    end

    // Stage j settles quotient bit QUO_W-1-j against the divisor shifted to match.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (rdy[j])
            begin
                tot_reg[j]   <= tot_src[j];
                neg_reg[j]   <= neg_src[j];
                ovf_reg[j]   <= ovf_src[j];
                degen_reg[j] <= degen_src[j];
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    if (rem_src[j][l] >= (REM_W'(tot_src[j]) << (QUO_W - 1 - j)))
                    begin
                        rem_reg[j][l] <= rem_src[j][l]
                                       - (REM_W'(tot_src[j]) << (QUO_W - 1 - j));
                        quo_reg[j][l] <= quo_src[j][l] | (QUO_W'(1) << (QUO_W - 1 - j));
                    end
                    else
                    begin
                        rem_reg[j][l] <= rem_src[j][l];
                        quo_reg[j][l] <= quo_src[j][l];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            out_data.quo[l] = quo_reg[DIV_STAGES-1][l];
        end
        out_data.neg   = neg_reg[DIV_STAGES-1];
        out_data.ovf   = ovf_reg[DIV_STAGES-1];
        out_data.degen = degen_reg[DIV_STAGES-1];
    end

endmodule

// File: src/triangle_barycentric_coords_unit.sv
// ============================================================================
// Triangle barycentric coordinate unit
// Pipelined barycentric weights of a point against a 3D triangle.
// ============================================================================
// Usage: one transfer on the s_ channel carries the three triangle vertices
// and the query point, twelve signed Q12.12 coordinates. One transfer on the
// m_ channel returns alpha, beta and gamma as saturated signed Q16.16 weights
// in m_tdata and the degenerate flag in m_tuser. Results leave in the order
// in which queries arrived, one result for each query.
// Each query passes through the edge differences and cross products, then the
// dot products, magnitudes and the overflow test, then division with one
// quotient bit per stage, and last saturation into the output register.
// Throughput is one query per cycle; a new transfer is taken every cycle
// while the downstream side keeps taking results.
// Reset clears every valid bit, so the pipeline comes up empty and ready.
// When the receiver stalls, full stages hold their data and empty stages
// ahead of the stall still fill, so s_tready only falls once the pipeline
// is full. Nothing is dropped or repeated.
// A triangle of zero area gives zero weights with m_tuser set.
// ============================================================================
module triangle_barycentric_coords_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, pt_x, pt_y, pt_z
    input  logic [bcc_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // alpha, beta, gamma
    output logic [bcc_pkg::OUT_TDATA_W-1:0] m_tdata,
    // degenerate
    output logic                            m_tuser
);
    import bcc_pkg::*;

    cvec_t      pa;
    cvec_t      pb;
    cvec_t      pc;
    cvec_t      pp;

    logic       cr_valid;
    logic       cr_ready;
    cross_set_t cr_data;
    logic       dt_valid;
    logic       dt_ready;
    div_in_t    dt_data;
    logic       dv_valid;
    logic       dv_ready;
    div_out_t   dv_data;

    logic                   out_vld_reg;
    logic [OUT_TDATA_W-1:0] tdata_reg;
    logic [OUT_TDATA_W-1:0] tdata_next;
    logic                   degen_reg;

    // Fields sit back to back from the lowest bit, vertex a first.
    assign pa.x = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign pa.y = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign pa.z = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign pb.x = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign pb.y = s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign pb.z = s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign pc.x = s_tdata[6*COORD_WIDTH +: COORD_WIDTH];
    assign pc.y = s_tdata[7*COORD_WIDTH +: COORD_WIDTH];
    assign pc.z = s_tdata[8*COORD_WIDTH +: COORD_WIDTH];
    assign pp.x = s_tdata[9*COORD_WIDTH +: COORD_WIDTH];
    assign pp.y = s_tdata[10*COORD_WIDTH +: COORD_WIDTH];
    assign pp.z = s_tdata[11*COORD_WIDTH +: COORD_WIDTH];

    bcc_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pa        (pa),
        .pb        (pb),
        .pc        (pc),
        .pp        (pp),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .out_data  (cr_data)
    );

    bcc_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .in_ready  (cr_ready),
        .in_data   (cr_data),
        .out_valid (dt_valid),
        .out_ready (dt_ready),
        .out_data  (dt_data)
    );

    bcc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dt_valid),
        .in_ready  (dt_ready),
        .in_data   (dt_data),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_data  (dv_data)
    );

    // The output register takes a new result whenever it is empty or being read.
    assign dv_ready = !out_vld_reg || m_tready;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            tdata_next[l*OUT_W +: OUT_W] = sat_weight(dv_data.quo[l], dv_data.neg[l],
                                                      dv_data.ovf[l], dv_data.degen);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (dv_ready)
        begin
            out_vld_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            tdata_reg <= tdata_next;
            degen_reg <= dv_data.degen;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = degen_reg;

`ifndef SYNTHESIS
    // A degenerate triangle must come out with all three weights cleared.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("degenerate result carries nonzero weights");

    // With the output register empty, every stage can move, so input is open.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    // A result taken while nothing waits behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !dv_valid |=> !m_tvalid)
        else $error("output stayed valid without a new result");
`endif

endmodule
